// ----- rtl/svm_pkg.sv -----
// shared types and constants for the split virtqueue manager
package svm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int TOP_W       = IDX_W + 1;
    localparam int CNT_W       = 16;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 16;

    localparam logic [LEN_W-1:0] MAX_FRAME = 16'd1514;

    localparam logic [0:0] REG_DEVICE_READY = 1'b0;

    typedef enum logic [1:0] {
        CMD_POST    = 2'd0,
        CMD_DONE    = 2'd1,
        CMD_RECLAIM = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK             = 3'd0,
        STS_NOT_READY      = 3'd1,
        STS_TOO_LONG       = 3'd2,
        STS_NO_FREE        = 3'd3,
        STS_NOTHING_USED   = 3'd4,
        STS_NOTHING_OUTSTD = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ADDR
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] buf_addr;
        logic [LEN_W-1:0]  length;
        logic [3:0]        done_id;
        logic [LEN_W-1:0]  done_len;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [3:0]        desc_index;
        logic [ADDR_W-1:0] out_addr;
        logic [LEN_W-1:0]  out_len;
        logic              notify;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] id;
        logic [LEN_W-1:0] len;
    } t_used_entry;

endpackage

// ----- rtl/svm_ram.sv -----
// generic synchronous ram, one write port and one registered read port
module svm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/split_virtqueue_manager_top.sv -----
// split virtqueue manager, driver side: descriptor stack, used ring and reclaim
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_data (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | apb psel/penable      | paddr, pwdata, prdata
//
// post, completion, unused command and rejected commands go through accept with
// memory read issue, then decision and write back.
// a successful reclaim adds a read before write back: the used ring read gives the
// descriptor id, which then addresses the descriptor address memory.
// reset is synchronous; free stack entries read as their own index until written.
// a stalled output holds the result and the block waits before write back.
module split_virtqueue_manager_top
    import svm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic               r_ready;
    logic [TOP_W-1:0]   r_free_top, n_free_top;
    logic [CNT_W-1:0]   r_used_wr, n_used_wr;
    logic [CNT_W-1:0]   r_used_cons, n_used_cons;
    logic [QUEUE_DEPTH-1:0] r_fs_valid;
    logic               r_fs_hit;
    logic [IDX_W-1:0]   r_rel_id, n_rel_id;
    logic [LEN_W-1:0]   r_clip_len, n_clip_len;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_reclaim_go;
    logic               w_cfg_wr;

    logic               w_fs_we;
    logic [IDX_W-1:0]   w_fs_waddr;
    logic [IDX_W-1:0]   w_fs_wdata;
    logic [IDX_W-1:0]   w_fs_rdata;
    logic [IDX_W-1:0]   w_free_id;

    logic               w_desc_we;
    logic [IDX_W-1:0]   w_desc_waddr;
    logic               w_desc_re;
    logic [ADDR_W-1:0]  w_desc_rdata;

    logic               w_used_we;
    t_used_entry        w_used_wdata;
    logic [$bits(t_used_entry)-1:0] w_used_rdata;
    t_used_entry        w_used_ent;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr[2:2] == REG_DEVICE_READY);

    assign w_used_ent = t_used_entry'(w_used_rdata);
    assign w_free_id  = r_fs_hit ? w_fs_rdata : r_free_top[IDX_W-1:0];

    assign w_reclaim_go = r_ready && (r_item.cmd == CMD_RECLAIM)
                          && (r_used_wr != r_used_cons) && (r_free_top != '0);

    svm_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_fs_we),
        .i_wr_addr (w_fs_waddr),
        .i_wr_data (w_fs_wdata),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_free_top[IDX_W-1:0]),
        .o_rd_data (w_fs_rdata)
    );

    svm_ram #(.WIDTH(ADDR_W), .DEPTH(QUEUE_DEPTH)) u_desc_addr (
        .i_clk     (i_clk),
        .i_wr_en   (w_desc_we),
        .i_wr_addr (w_desc_waddr),
        .i_wr_data (r_item.buf_addr),
        .i_rd_en   (w_desc_re),
        .i_rd_addr (w_used_ent.id),
        .o_rd_data (w_desc_rdata)
    );

    svm_ram #(.WIDTH($bits(t_used_entry)), .DEPTH(QUEUE_DEPTH)) u_used_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_used_we),
        .i_wr_addr (r_used_wr[IDX_W-1:0]),
        .i_wr_data (w_used_wdata),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_used_cons[IDX_W-1:0]),
        .o_rd_data (w_used_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_reclaim_go) begin
                    n_state = S_ADDR;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADDR: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_out_load   = 1'b0;
        w_fs_we      = 1'b0;
        w_fs_waddr   = '0;
        w_fs_wdata   = r_rel_id;
        w_desc_we    = 1'b0;
        w_desc_waddr = w_free_id;
        w_desc_re    = 1'b0;
        w_used_we    = 1'b0;
        w_used_wdata = '{id: r_item.done_id[IDX_W-1:0], len: r_item.done_len};
        n_free_top   = r_free_top;
        n_used_wr    = r_used_wr;
        n_used_cons  = r_used_cons;
        n_rel_id     = r_rel_id;
        n_clip_len   = r_clip_len;
        n_out        = '{status: STS_OK, desc_index: '0, out_addr: '0, out_len: '0,
                         notify: 1'b0};
        case (r_state)
            S_READ: begin
                if (w_reclaim_go) begin
                    w_desc_re  = 1'b1;
                    n_rel_id   = w_used_ent.id;
                    n_clip_len = (w_used_ent.len > r_item.length) ? r_item.length
                                                                  : w_used_ent.len;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (!r_ready) begin
                        n_out.status = STS_NOT_READY;
                    end else begin
                        case (r_item.cmd)
                            CMD_POST: begin
                                if (r_item.length > MAX_FRAME) begin
                                    n_out.status = STS_TOO_LONG;
                                end else if (r_free_top >= TOP_W'(QUEUE_DEPTH)) begin
                                    n_out.status = STS_NO_FREE;
                                end else begin
                                    w_desc_we        = 1'b1;
                                    n_free_top       = r_free_top + TOP_W'(1);
                                    n_out.desc_index = 4'(w_free_id);
                                    n_out.notify     = 1'b1;
                                end
                            end
                            CMD_DONE: begin
                                w_used_we        = 1'b1;
                                n_used_wr        = r_used_wr + CNT_W'(1);
                                n_out.desc_index = 4'(w_used_wdata.id);
                            end
                            CMD_RECLAIM: begin
                                if (r_used_wr == r_used_cons) begin
                                    n_out.status = STS_NOTHING_USED;
                                end else begin
                                    n_out.status = STS_NOTHING_OUTSTD;
                                end
                            end
                            CMD_NONE: begin
                                n_out.status = STS_OK;
                            end
                            default: begin
                                n_out.status = STS_OK;
                            end
                        endcase
                    end
                end
            end
            S_ADDR: begin
                if (w_out_free) begin
                    w_out_load       = 1'b1;
                    n_free_top       = r_free_top - TOP_W'(1);
                    w_fs_we          = 1'b1;
                    w_fs_waddr       = n_free_top[IDX_W-1:0];
                    n_used_cons      = r_used_cons + CNT_W'(1);
                    n_out.desc_index = 4'(r_rel_id);
                    n_out.out_addr   = w_desc_rdata;
                    n_out.out_len    = r_clip_len;
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_free_top  <= '0;
            r_used_wr   <= '0;
            r_used_cons <= '0;
            r_fs_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_used_wr   <= n_used_wr;
            r_used_cons <= n_used_cons;
            r_out_valid <= w_out_load || (r_out_valid && i_out_stall);
            if (w_cfg_wr) begin
                r_ready <= pwdata[0];
            end
            if (w_fs_we) begin
                r_fs_valid[w_fs_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item   <= i_in_data;
            r_fs_hit <= r_fs_valid[r_free_top[IDX_W-1:0]];
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
        r_rel_id   <= n_rel_id;
        r_clip_len <= n_clip_len;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2:2] == REG_DEVICE_READY) ? {31'b0, r_ready} : 32'b0;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= TOP_W'(QUEUE_DEPTH))
        else $error("free stack top beyond depth");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_READ))
        else $error("accepted item did not enter the read state");

    a_post_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && n_out.notify) |=> (r_free_top == $past(r_free_top) + TOP_W'(1)))
        else $error("successful post did not pop the free stack");

    a_reclaim_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_state == S_ADDR)) |=>
            (r_free_top == $past(r_free_top) - TOP_W'(1)))
        else $error("reclaim did not push the free stack");

endmodule

// ----- tb/split_virtqueue_manager_top_tb.sv -----
// testbench for the split virtqueue manager: directed and random commands checked against a predictor
module split_virtqueue_manager_top_tb;
    import svm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] READY_ADDR = 3'(4 * REG_DEVICE_READY);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    split_virtqueue_manager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predicted queue state
    logic                   ready_bit;
    logic [ADDR_W-1:0]      addr_tab [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] addr_known;
    logic [IDX_W-1:0]       free_ids [QUEUE_DEPTH];
    logic [TOP_W-1:0]       free_top;
    logic [IDX_W-1:0]       used_ids [QUEUE_DEPTH];
    logic [LEN_W-1:0]       used_lens [QUEUE_DEPTH];
    logic [CNT_W-1:0]       used_wr;
    logic [CNT_W-1:0]       used_rd;

    t_out_item        pending_results [$];
    logic [IDX_W-1:0] in_flight [$];
    t_out_item        want_r;
    int               status_seen [8];
    int               items_sent;
    int               results_checked;
    int               mismatches;
    bit               no_gaps;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [IDX_W-1:0] pick_known();
        logic [IDX_W-1:0] d;
        do d = IDX_W'($urandom_range(QUEUE_DEPTH - 1)); while (!addr_known[d]);
        return d;
    endfunction

    function automatic t_in_item make_item(input t_cmd c, input logic [ADDR_W-1:0] a,
                                           input logic [LEN_W-1:0] l, input logic [3:0] d,
                                           input logic [LEN_W-1:0] dl);
        t_in_item x;
        x.cmd      = c;
        x.buf_addr = a;
        x.length   = l;
        x.done_id  = d;
        x.done_len = dl;
        return x;
    endfunction

    function automatic t_out_item virtq_predict(input t_in_item x);
        t_out_item        r;
        logic [IDX_W-1:0] d;
        logic [LEN_W-1:0] l;
        r = '0;
        if (!ready_bit) begin
            r.status = STS_NOT_READY;
        end else begin
            case (x.cmd)
                CMD_POST: begin
                    if (x.length > MAX_FRAME) begin
                        r.status = STS_TOO_LONG;
                    end else if (free_top >= QUEUE_DEPTH) begin
                        r.status = STS_NO_FREE;
                    end else begin
                        d = free_ids[free_top[IDX_W-1:0]];
                        free_top++;
                        addr_tab[d] = x.buf_addr;
                        addr_known[d] = 1'b1;
                        r.desc_index = d;
                        r.notify = 1'b1;
                    end
                end
                CMD_DONE: begin
                    d = x.done_id;
                    used_ids[used_wr[IDX_W-1:0]] = d;
                    used_lens[used_wr[IDX_W-1:0]] = x.done_len;
                    used_wr++;
                    r.desc_index = d;
                end
                CMD_RECLAIM: begin
                    if (used_wr == used_rd) begin
                        r.status = STS_NOTHING_USED;
                    end else if (free_top == 0) begin
                        r.status = STS_NOTHING_OUTSTD;
                    end else begin
                        d = used_ids[used_rd[IDX_W-1:0]];
                        l = used_lens[used_rd[IDX_W-1:0]];
                        if (l > x.length) l = x.length;
                        r.out_addr = addr_tab[d];
                        r.out_len = l;
                        free_top--;
                        free_ids[free_top[IDX_W-1:0]] = d;
                        used_rd++;
                        r.desc_index = d;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic send_cmd(input t_in_item x, output t_out_item res);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= x;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = virtq_predict(x);
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic post_buf(input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] a);
        t_out_item res;
        send_cmd(make_item(CMD_POST, a, len, 4'($urandom), 16'($urandom)), res);
        if (res.notify) in_flight.push_back(res.desc_index);
    endtask

    task automatic complete_one(input logic [LEN_W-1:0] dlen, input bit allow_stray);
        t_out_item        res;
        int               k;
        logic [IDX_W-1:0] d;
        if (!ready_bit) begin
            d = IDX_W'($urandom);
        end else if (in_flight.size() > 0 && !(allow_stray && $urandom_range(9) == 0)) begin
            k = $urandom_range(in_flight.size() - 1);
            d = in_flight[k];
            in_flight.delete(k);
        end else begin
            d = pick_known();
        end
        send_cmd(make_item(CMD_DONE, rand_addr(), 16'($urandom), d, dlen), res);
    endtask

    task automatic reclaim_buf(input logic [LEN_W-1:0] cap);
        t_out_item res;
        send_cmd(make_item(CMD_RECLAIM, rand_addr(), cap, 4'($urandom), 16'($urandom)), res);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_ready_reg();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= READY_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== ready_bit) begin
            mismatches++;
            if (mismatches <= 10)
                $display("device_ready readback: expected %0b, got %0b", ready_bit, prdata[0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ready(input logic v);
        logic [31:0] val;
        wait_idle();
        val = {31'($urandom_range(32'h7fff_ffff)), v};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= READY_ADDR;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ready_bit = val[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_ready_reg();
    endtask

    task automatic test_not_ready();
        t_out_item res;
        check_ready_reg();
        set_ready(1'b0);
        post_buf(16'd64, rand_addr());
        send_cmd(make_item(CMD_DONE, rand_addr(), 16'hffff, 4'hf, 16'hffff), res);
        reclaim_buf(16'hffff);
    endtask

    task automatic test_post_checks();
        t_out_item res;
        set_ready(1'b1);
        post_buf(16'(MAX_FRAME + 1), rand_addr());
        post_buf(MAX_FRAME, '1);
        post_buf(16'd0, '0);
        reclaim_buf(16'($urandom));
        send_cmd(make_item(CMD_NONE, '1, 16'hffff, 4'hf, 16'hffff), res);
    endtask

    task automatic test_stack_exhaust();
        while (free_top < QUEUE_DEPTH) post_buf(16'($urandom_range(MAX_FRAME)), rand_addr());
        // too long is reported ahead of an empty free stack
        post_buf(16'hffff, rand_addr());
        post_buf(16'd64, rand_addr());
    endtask

    task automatic test_reclaim_clip();
        complete_one(16'hffff, 1'b0);
        reclaim_buf(16'd100);
        complete_one(16'd0, 1'b0);
        reclaim_buf(16'hffff);
        complete_one(16'd1000, 1'b0);
        reclaim_buf(16'd1000);
    endtask

    task automatic test_nothing_outstanding();
        int n;
        n = in_flight.size();
        while (in_flight.size() > 0) complete_one(16'($urandom), 1'b0);
        repeat (n) reclaim_buf(16'($urandom));
        // every descriptor is free now, so a stale used entry cannot be reclaimed
        complete_one(16'($urandom), 1'b0);
        reclaim_buf(16'($urandom));
        reclaim_buf(16'($urandom));
        post_buf(16'd200, rand_addr());
        reclaim_buf(16'($urandom));
        post_buf(16'd300, rand_addr());
        post_buf(16'd400, rand_addr());
    endtask

    task automatic test_used_overrun();
        repeat (6) post_buf(16'($urandom_range(MAX_FRAME)), rand_addr());
        repeat (20) complete_one(16'($urandom), 1'b1);
        repeat (10) reclaim_buf(16'($urandom));
    endtask

    task automatic random_cmds(input int n);
        t_out_item res;
        int        r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 36) begin
                post_buf(($urandom_range(9) == 0) ? 16'($urandom_range(65535, MAX_FRAME + 1))
                                                  : 16'($urandom_range(MAX_FRAME)), rand_addr());
            end else if (r < 66) begin
                complete_one(16'($urandom), 1'b1);
            end else if (r < 95) begin
                reclaim_buf(($urandom_range(3) == 0) ? 16'($urandom_range(64)) : 16'($urandom));
            end else begin
                send_cmd(make_item(CMD_NONE, rand_addr(), 16'($urandom), 4'($urandom),
                                   16'($urandom)), res);
            end
        end
    endtask

    task automatic test_random_traffic();
        random_cmds(110);
        no_gaps = 1'b1;
        random_cmds(50);
        no_gaps = 1'b0;
        set_ready(1'b0);
        random_cmds(20);
        set_ready(1'b1);
        random_cmds(120);
    endtask

    // result stall, bursts of random length
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            repeat (1 + $urandom_range(6)) @(negedge i_clk);
            n = idle_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with none expected: %p", o_out_data);
            end else begin
                want_r = pending_results.pop_front();
                status_seen[want_r.status]++;
                if (o_out_data !== want_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: status %0d/%0d index %0d/%0d addr %h/%h ",
                                  "len %0d/%0d notify %0b/%0b"},
                                 results_checked, want_r.status, o_out_data.status,
                                 want_r.desc_index, o_out_data.desc_index,
                                 want_r.out_addr, o_out_data.out_addr,
                                 want_r.out_len, o_out_data.out_len,
                                 want_r.notify, o_out_data.notify);
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        no_gaps    = 1'b0;
        ready_bit  = 1'b0;
        addr_known = '0;
        free_top   = '0;
        used_wr    = '0;
        used_rd    = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) free_ids[i] = IDX_W'(i);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_not_ready();
        test_post_checks();
        test_stack_exhaust();
        test_reclaim_clip();
        test_nothing_outstanding();
        test_used_overrun();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d commands over ready and not-ready phases, %0d results, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display({"status mix: ok %0d, not ready %0d, too long %0d, no free %0d, ",
                  "none used %0d, none out %0d"},
                 status_seen[STS_OK], status_seen[STS_NOT_READY], status_seen[STS_TOO_LONG],
                 status_seen[STS_NO_FREE], status_seen[STS_NOTHING_USED],
                 status_seen[STS_NOTHING_OUTSTD]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
